// ===== rtl/core/tgc_pkg.sv =====
// Shared constants, types and functions of the tilt gesture lane signal classifier.
`default_nettype none

package tgc_pkg;

   // Depth of the pitch window and the widths that follow from it.
   localparam int WINDOW = 32;
   localparam int IDX_W  = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);

   // Field widths.
   localparam int ANGLE_W    = 13;
   localparam int CENTER_W   = 12;
   localparam int TOL_W      = 11;
   localparam int BAND_W     = 14;
   localparam int LANE_W     = 3;
   localparam int KIND_W     = 2;
   localparam int CODE_W     = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_CENTER    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_TOLERANCE = 1'd1;

   // Register reset values.
   localparam logic signed [CENTER_W-1:0] CENTER_RESET = 12'sd1440;
   localparam logic [TOL_W-1:0]           TOL_RESET    = 11'd320;

   // Lane boundaries: 45 and 135 degrees in 1/16 degree.
   localparam logic signed [ANGLE_W-1:0] YAW_Q45  = 13'sd720;
   localparam logic signed [ANGLE_W-1:0] YAW_Q135 = 13'sd2160;

   // Lane numbers.
   localparam logic [LANE_W-1:0] LANE_TOP    = 3'd1;
   localparam logic [LANE_W-1:0] LANE_RIGHT  = 3'd2;
   localparam logic [LANE_W-1:0] LANE_BOTTOM = 3'd3;
   localparam logic [LANE_W-1:0] LANE_LEFT   = 3'd4;

   // Signal kinds.
   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RED   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GREEN = 2'd2;

   // Code reported when there is no action (minus one in seven bits).
   localparam logic [CODE_W-1:0] CODE_NONE = 7'h7F;

   // Green needs strictly more than this many samples in each class.
   localparam logic [CNT_W-1:0] GREEN_MIN = CNT_W'(2);

   // Position of one pitch sample relative to the band.
   typedef struct packed {
      logic below;
      logic above;
      logic in_band;
   } tgc_class_type;

   // Access to the window memory, as driven in each cycle.
   typedef struct packed {
      logic                      rd_en;
      logic                      wr_en;
      logic [IDX_W-1:0]          addr;
      logic signed [ANGLE_W-1:0] wr_data;
   } tgc_mem_req_type;

   // Classifies a pitch sample against the band lo..hi. Inside is strict.
   function automatic tgc_class_type classify(
      input logic signed [ANGLE_W-1:0] sample,
      input logic signed [BAND_W-1:0]  lo,
      input logic signed [BAND_W-1:0]  hi
   );
      logic signed [BAND_W-1:0] p;
      tgc_class_type            c;
      p         = BAND_W'(sample);
      c.below   = (p < lo);
      c.above   = (p > hi);
      c.in_band = (p > lo) && (p < hi);
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tgc_req_if.sv =====
// Input channel of the classifier: one yaw and pitch sample per transfer.
`default_nettype none

interface tgc_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [tgc_pkg::ANGLE_W-1:0]        yaw_angle;
   logic signed [tgc_pkg::ANGLE_W-1:0]        pitch_angle;

   modport source (output valid, output yaw_angle, output pitch_angle, input ready);
   modport sink   (input valid, input yaw_angle, input pitch_angle, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tgc_rsp_if.sv =====
// Result channel of the classifier: lane, signal kind and lane action code.
`default_nettype none

interface tgc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [tgc_pkg::LANE_W-1:0]          lane_number;
   logic [tgc_pkg::KIND_W-1:0]          signal_kind;
   logic signed [tgc_pkg::CODE_W-1:0]   lane_action_code;

   modport source (output valid, output lane_number, output signal_kind,
                   output lane_action_code, input ready);
   modport sink   (input valid, input lane_number, input signal_kind,
                   input lane_action_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tgc_pitch_window.sv =====
// Circular pitch window memory with per-entry valid bits and registered read.
`default_nettype none

module tgc_pitch_window (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire tgc_pkg::tgc_mem_req_type               mem_req,
   output logic signed [tgc_pkg::ANGLE_W-1:0]          rd_data
);

   logic signed [tgc_pkg::ANGLE_W-1:0] mem [tgc_pkg::WINDOW];
   logic [tgc_pkg::WINDOW-1:0]         entry_valid_ff;
   logic signed [tgc_pkg::ANGLE_W-1:0] rd_data_ff;
   logic                               rd_valid_ff;

   // A read in the same cycle as a write to that entry returns the old sample.
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff  <= mem[mem_req.addr];
         rd_valid_ff <= entry_valid_ff[mem_req.addr];
      end
      if (mem_req.wr_en) begin
         mem[mem_req.addr] <= mem_req.wr_data;
      end
   end

   // Entries never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (mem_req.wr_en) begin
         entry_valid_ff[mem_req.addr] <= 1'b1;
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// ===== rtl/core/tilt_gesture_lane_signal_classifier.sv =====
// Top level of the tilt gesture lane signal classifier.
`default_nettype none

// The block takes one transfer per clock cycle on req_chan while no scan runs and the
// result side does not stall, and returns exactly one result per sample on rsp_chan
// through the first stage register and the output register. The last WINDOW pitch samples
// live in a circular memory; three running counts (below, above and strictly inside the
// band) are kept in registers. Each accepted sample reads the entry it evicts and writes
// itself in the same cycle; as the sample leaves the first stage the evicted sample
// leaves the counts, the new one enters and the result is formed, so the sustained rate
// of one sample per cycle is set by the single memory port serving one read and one write
// per sample. The counts depend on the band, so after reset and after every register
// write the block scans the whole window to rebuild them, with req_chan.ready low.
// Register writes belong in times when no sample is in flight, and each one restarts the
// scan. Lanes follow the yaw quadrant (top, right, bottom, left); the action is red when
// every windowed pitch lies in the band, bounds included, and green, which wins over red,
// when more than two samples each lie below, above and strictly inside the band.

module tilt_gesture_lane_signal_classifier (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   tgc_req_if.sink                                   req_chan,
   tgc_rsp_if.source                                 rsp_chan,
   input  wire logic                                 csr_wr_en,
   input  wire logic [tgc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [tgc_pkg::CSR_DATA_W-1:0]       csr_wr_data
);

   // Run accepts samples; scan reads the window; drain folds in the last scanned entry.
   typedef enum logic [2:0] {
      ST_RUN   = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type                                  state_ff, state_in;
   logic [tgc_pkg::IDX_W-1:0]                  scan_idx_ff, scan_idx_in;
   logic                                       scan_acc_ff, scan_acc_in;
   logic [tgc_pkg::IDX_W-1:0]                  wr_ptr_ff, wr_ptr_in;

   logic signed [tgc_pkg::CENTER_W-1:0]        center_ff, center_in;
   logic [tgc_pkg::TOL_W-1:0]                  tol_ff, tol_in;
   logic signed [tgc_pkg::BAND_W-1:0]          band_lo, band_hi;

   logic [tgc_pkg::CNT_W-1:0]                  below_ff, below_in;
   logic [tgc_pkg::CNT_W-1:0]                  above_ff, above_in;
   logic [tgc_pkg::CNT_W-1:0]                  inside_ff, inside_in;
   logic [tgc_pkg::CNT_W-1:0]                  below_upd, above_upd, inside_upd;
   logic [tgc_pkg::CNT_W+1:0]                  count_sum;

   logic                                       s1_valid_ff, s1_valid_in;
   logic signed [tgc_pkg::ANGLE_W-1:0]         s1_pitch_ff;
   logic [tgc_pkg::LANE_W-1:0]                 s1_lane_ff;

   logic                                       rsp_valid_ff, rsp_valid_in;
   logic [tgc_pkg::LANE_W-1:0]                 rsp_lane_ff;
   logic [tgc_pkg::KIND_W-1:0]                 rsp_kind_ff;
   logic [tgc_pkg::CODE_W-1:0]                 rsp_code_ff;

   logic                                       req_ready;
   logic                                       accept;
   logic                                       s1_advance;
   logic                                       s1_fire;
   logic [tgc_pkg::LANE_W-1:0]                 lane;
   logic [tgc_pkg::KIND_W-1:0]                 kind;
   logic [tgc_pkg::CODE_W-1:0]                 code;
   logic [tgc_pkg::CODE_W-1:0]                 lane_tens;
   logic                                       green, red;

   tgc_pkg::tgc_mem_req_type                   mem_req;
   logic signed [tgc_pkg::ANGLE_W-1:0]         rd_data;
   tgc_pkg::tgc_class_type                     new_cls, old_cls;

   // ---------------------------------------------------------------------------------
   // Configuration registers and the band they define. The band edges are exact: a
   // 12-bit centre and an 11-bit tolerance fit in 14 signed bits either way.
   // ---------------------------------------------------------------------------------
   always_comb begin
      center_in = center_ff;
      tol_in    = tol_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            tgc_pkg::CSR_PITCH_CENTER: begin
               center_in = csr_wr_data[tgc_pkg::CENTER_W-1:0];
            end
            tgc_pkg::CSR_PITCH_TOLERANCE: begin
               tol_in = csr_wr_data[tgc_pkg::TOL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign band_lo = tgc_pkg::BAND_W'(center_ff) - $signed(tgc_pkg::BAND_W'(tol_ff));
   assign band_hi = tgc_pkg::BAND_W'(center_ff) + $signed(tgc_pkg::BAND_W'(tol_ff));

   // ---------------------------------------------------------------------------------
   // Handshake. A sample is taken when no scan is running and the first stage is free
   // or moves on in this cycle; whether it moves on follows rsp_chan.ready combinationally.
   // ---------------------------------------------------------------------------------
   assign s1_advance     = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire        = s1_valid_ff && s1_advance;
   assign req_ready      = (state_ff == ST_RUN) && (!s1_valid_ff || s1_advance);
   assign req_chan.ready = req_ready;
   assign accept         = req_chan.valid && req_ready;

   // Lane from the yaw quadrant.
   always_comb begin
      if (req_chan.yaw_angle >= -tgc_pkg::YAW_Q45 && req_chan.yaw_angle < tgc_pkg::YAW_Q45) begin
         lane = tgc_pkg::LANE_TOP;
      end else if (req_chan.yaw_angle >= tgc_pkg::YAW_Q45 &&
                   req_chan.yaw_angle < tgc_pkg::YAW_Q135) begin
         lane = tgc_pkg::LANE_RIGHT;
      end else if (req_chan.yaw_angle >= tgc_pkg::YAW_Q135 ||
                   req_chan.yaw_angle < -tgc_pkg::YAW_Q135) begin
         lane = tgc_pkg::LANE_BOTTOM;
      end else begin
         lane = tgc_pkg::LANE_LEFT;
      end
   end

   // ---------------------------------------------------------------------------------
   // Window memory. An accepted sample reads out the entry it replaces and overwrites
   // it in the same cycle; during a scan the memory is read one entry per cycle.
   // ---------------------------------------------------------------------------------
   always_comb begin
      mem_req.rd_en   = accept || (state_ff == ST_SCAN);
      mem_req.wr_en   = accept;
      mem_req.addr    = accept ? wr_ptr_ff : scan_idx_ff;
      mem_req.wr_data = req_chan.pitch_angle;
   end

   tgc_pitch_window u_window (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign wr_ptr_in = !accept ? wr_ptr_ff :
                      (wr_ptr_ff == tgc_pkg::IDX_W'(tgc_pkg::WINDOW - 1)) ? '0 :
                      wr_ptr_ff + 1'b1;

   // ---------------------------------------------------------------------------------
   // Scan sequencer. Reset and every register write restart it with cleared counts.
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      scan_acc_in = (state_ff == ST_SCAN);
      unique case (state_ff)
         ST_RUN: begin
         end
         ST_SCAN: begin
            scan_idx_in = scan_idx_ff + 1'b1;
            if (scan_idx_ff == tgc_pkg::IDX_W'(tgc_pkg::WINDOW - 1)) begin
               scan_idx_in = '0;
               state_in    = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_SCAN;
         end
      endcase
      if (csr_wr_en) begin
         state_in    = ST_SCAN;
         scan_idx_in = '0;
         scan_acc_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------------------
   // Running counts. The evicted sample is what the memory read out at acceptance;
   // in a scan the same read data is the entry being counted.
   // ---------------------------------------------------------------------------------
   assign new_cls = tgc_pkg::classify(s1_pitch_ff, band_lo, band_hi);
   assign old_cls = tgc_pkg::classify(rd_data, band_lo, band_hi);

   assign below_upd  = below_ff  + tgc_pkg::CNT_W'(new_cls.below)  -
                       tgc_pkg::CNT_W'(old_cls.below);
   assign above_upd  = above_ff  + tgc_pkg::CNT_W'(new_cls.above)  -
                       tgc_pkg::CNT_W'(old_cls.above);
   assign inside_upd = inside_ff + tgc_pkg::CNT_W'(new_cls.in_band) -
                       tgc_pkg::CNT_W'(old_cls.in_band);

   always_comb begin
      below_in  = below_ff;
      above_in  = above_ff;
      inside_in = inside_ff;
      if (csr_wr_en) begin
         below_in  = '0;
         above_in  = '0;
         inside_in = '0;
      end else if (scan_acc_ff) begin
         below_in  = below_ff  + tgc_pkg::CNT_W'(old_cls.below);
         above_in  = above_ff  + tgc_pkg::CNT_W'(old_cls.above);
         inside_in = inside_ff + tgc_pkg::CNT_W'(old_cls.in_band);
      end else if (s1_fire) begin
         below_in  = below_upd;
         above_in  = above_upd;
         inside_in = inside_upd;
      end
   end

   // ---------------------------------------------------------------------------------
   // Result. Green wins over red; the code is lane times ten plus one for green.
   // ---------------------------------------------------------------------------------
   assign green = (below_upd > tgc_pkg::GREEN_MIN) && (above_upd > tgc_pkg::GREEN_MIN) &&
                  (inside_upd > tgc_pkg::GREEN_MIN);
   assign red   = (below_upd == '0) && (above_upd == '0);

   assign lane_tens = tgc_pkg::CODE_W'({s1_lane_ff, 3'b000}) +
                      tgc_pkg::CODE_W'({s1_lane_ff, 1'b0});

   always_comb begin
      if (green) begin
         kind = tgc_pkg::KIND_GREEN;
         code = lane_tens + tgc_pkg::CODE_W'(1);
      end else if (red) begin
         kind = tgc_pkg::KIND_RED;
         code = lane_tens;
      end else begin
         kind = tgc_pkg::KIND_NONE;
         code = tgc_pkg::CODE_NONE;
      end
   end

   assign s1_valid_in  = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // ---------------------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SCAN;
         scan_idx_ff  <= '0;
         scan_acc_ff  <= 1'b0;
         wr_ptr_ff    <= '0;
         center_ff    <= tgc_pkg::CENTER_RESET;
         tol_ff       <= tgc_pkg::TOL_RESET;
         below_ff     <= '0;
         above_ff     <= '0;
         inside_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         scan_acc_ff  <= scan_acc_in;
         wr_ptr_ff    <= wr_ptr_in;
         center_ff    <= center_in;
         tol_ff       <= tol_in;
         below_ff     <= below_in;
         above_ff     <= above_in;
         inside_ff    <= inside_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pitch_ff <= req_chan.pitch_angle;
         s1_lane_ff  <= lane;
      end
      if (s1_fire) begin
         rsp_lane_ff <= s1_lane_ff;
         rsp_kind_ff <= kind;
         rsp_code_ff <= code;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.lane_number      = rsp_lane_ff;
   assign rsp_chan.signal_kind      = rsp_kind_ff;
   assign rsp_chan.lane_action_code = $signed(rsp_code_ff);

   // ---------------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------------
   assign count_sum = (tgc_pkg::CNT_W + 2)'(below_ff) + (tgc_pkg::CNT_W + 2)'(above_ff) +
                      (tgc_pkg::CNT_W + 2)'(inside_ff);

   // The three classes are disjoint, so together they never exceed the window depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_sum <= (tgc_pkg::CNT_W + 2)'(tgc_pkg::WINDOW))
      else $error("running counts exceed the window depth");

   // A register write starts a rescan, so no sample is taken in the following cycle.
   a_write_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !req_chan.ready)
      else $error("sample accepted straight after a register write");

   // Every accepted sample occupies the first stage in the next cycle.
   a_accept_to_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted sample lost before the first stage");

   // A sample leaving the first stage always lands in the output register.
   a_s1_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_chan.valid)
      else $error("result lost between the first stage and the output");

   // The first stage holds no sample while the window is being rescanned.
   a_scan_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !$past(csr_wr_en)) |-> !s1_valid_ff)
      else $error("sample in flight during a window scan");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench of the tilt gesture lane signal classifier.
`timescale 1ns / 1ps

module testbench;

   // Run control: clock period, watchdog and the quiet time allowed at the end.
   localparam int HALF_PERIOD  = 10;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE_TICKS = 8;
   localparam int REPORT_MAX   = 10;

   // Random part: number of register settings and samples taken under each.
   localparam int PHASES           = 12;
   localparam int SAMPLES_PER_PASS = 115;

   // Behaviour of the block: lane edges (45 and 135 degrees in 1/16 degree),
   // register values after reset and the class count that green must exceed.
   localparam int YAW_45       = 720;
   localparam int YAW_135      = 2160;
   localparam int RESET_CENTER = 1440;
   localparam int RESET_TOL    = 320;
   localparam int GREEN_FLOOR  = 2;
   localparam int LANE_SCALE   = 10;

   // Low digit of the lane action code.
   localparam logic [tgc_pkg::CODE_W-1:0] ACTION_RED   = 7'd0;
   localparam logic [tgc_pkg::CODE_W-1:0] ACTION_GREEN = 7'd1;

   // One result of the block, as the checker expects it.
   typedef struct packed {
      logic [tgc_pkg::LANE_W-1:0] lane;
      logic [tgc_pkg::KIND_W-1:0] kind;
      logic [tgc_pkg::CODE_W-1:0] code;
   } lane_signal_type;

   // A row of the directed table is either a sample or a register write.
   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_op_type;

   typedef struct packed {
      row_op_type                          op;
      logic                                typed;
      logic signed [tgc_pkg::ANGLE_W-1:0]  yaw;
      logic signed [tgc_pkg::ANGLE_W-1:0]  pitch;
      logic [tgc_pkg::CSR_IDX_W-1:0]       csr_idx;
      logic [tgc_pkg::CSR_DATA_W-1:0]      csr_data;
      lane_signal_type                     want;
   } stim_row_type;

   // Where the random pitch of the next sample is placed relative to the band.
   typedef enum logic [1:0] {MODE_STEADY, MODE_MIXED, MODE_EDGE, MODE_NOISE} pitch_mode_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [tgc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [tgc_pkg::CSR_DATA_W-1:0] csr_wr_data;

   tgc_req_if req_bus ();
   tgc_rsp_if rsp_bus ();

   tilt_gesture_lane_signal_classifier dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Mirror of the block's state: the pitch window, oldest sample first, and
   // the two band registers as last written.
   logic signed [tgc_pkg::ANGLE_W-1:0]  pitch_history [tgc_pkg::WINDOW];
   logic signed [tgc_pkg::CENTER_W-1:0] center_copy;
   logic [tgc_pkg::TOL_W-1:0]           tol_copy;

   stim_row_type    stim_table [$];
   lane_signal_type pending_signals [$];

   int   fault_count = 0;
   int   cycle_count = 0;
   logic full_rate   = 1'b0;

   // The clock runs from time zero; reset is held high at the start and then released.
   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Lower band edge, in plain integers so that nothing saturates.
   function automatic int band_low();
      return int'(center_copy) - int'(tol_copy);
   endfunction

   function automatic int band_high();
      return int'(center_copy) + int'(tol_copy);
   endfunction

   // Shifts one pitch into the mirrored window and works out the lane, the
   // action and the code that the block must report for this sample.
   function automatic lane_signal_type signal_for_sample(
      input logic signed [tgc_pkg::ANGLE_W-1:0] yaw,
      input logic signed [tgc_pkg::ANGLE_W-1:0] pitch
   );
      int lo;
      int hi;
      int p;
      int y;
      int below;
      int above;
      int in_band;
      lane_signal_type s;
      lo      = band_low();
      hi      = band_high();
      below   = 0;
      above   = 0;
      in_band = 0;
      for (int i = 0; i < tgc_pkg::WINDOW - 1; i++) pitch_history[i] = pitch_history[i + 1];
      pitch_history[tgc_pkg::WINDOW - 1] = pitch;
      foreach (pitch_history[i]) begin
         p = int'(pitch_history[i]);
         if (p < lo) below++;
         if (p > hi) above++;
         if (p > lo && p < hi) in_band++;
      end
      y = int'(yaw);
      if (y >= -YAW_45 && y < YAW_45) s.lane = tgc_pkg::LANE_TOP;
      else if (y >= YAW_45 && y < YAW_135) s.lane = tgc_pkg::LANE_RIGHT;
      else if (y >= YAW_135 || y < -YAW_135) s.lane = tgc_pkg::LANE_BOTTOM;
      else s.lane = tgc_pkg::LANE_LEFT;
      // Green wins over red; red needs every sample within the closed band.
      if (below > GREEN_FLOOR && above > GREEN_FLOOR && in_band > GREEN_FLOOR) begin
         s.kind = tgc_pkg::KIND_GREEN;
         s.code = 7'(s.lane * LANE_SCALE) + ACTION_GREEN;
      end else if (below == 0 && above == 0) begin
         s.kind = tgc_pkg::KIND_RED;
         s.code = 7'(s.lane * LANE_SCALE) + ACTION_RED;
      end else begin
         s.kind = tgc_pkg::KIND_NONE;
         s.code = tgc_pkg::CODE_NONE;
      end
      return s;
   endfunction

   // Table builders for the directed part.
   function automatic void add_sample(input int yaw, input int pitch);
      stim_row_type r;
      r         = '0;
      r.op      = ROW_SAMPLE;
      r.yaw     = 13'(yaw);
      r.pitch   = 13'(pitch);
      stim_table.push_back(r);
   endfunction

   function automatic void add_typed(
      input int                         yaw,
      input int                         pitch,
      input logic [tgc_pkg::LANE_W-1:0] lane,
      input logic [tgc_pkg::KIND_W-1:0] kind,
      input logic [tgc_pkg::CODE_W-1:0] code
   );
      stim_row_type r;
      r           = '0;
      r.op        = ROW_SAMPLE;
      r.typed     = 1'b1;
      r.yaw       = 13'(yaw);
      r.pitch     = 13'(pitch);
      r.want.lane = lane;
      r.want.kind = kind;
      r.want.code = code;
      stim_table.push_back(r);
   endfunction

   function automatic void add_write(input logic [tgc_pkg::CSR_IDX_W-1:0] idx, input int data);
      stim_row_type r;
      r          = '0;
      r.op       = ROW_WRITE;
      r.csr_idx  = idx;
      r.csr_data = 12'(data);
      stim_table.push_back(r);
   endfunction

   function automatic void build_table();
      // Straight after reset the window is all zeros, well below the default band,
      // so nothing can fire and only the lane moves. These rows walk every lane
      // edge and both extremes of the yaw field.
      add_typed(0, 0, tgc_pkg::LANE_TOP, tgc_pkg::KIND_NONE, tgc_pkg::CODE_NONE);
      add_typed(-4096, 0, tgc_pkg::LANE_BOTTOM, tgc_pkg::KIND_NONE, tgc_pkg::CODE_NONE);
      add_typed(4095, 0, tgc_pkg::LANE_BOTTOM, tgc_pkg::KIND_NONE, tgc_pkg::CODE_NONE);
      add_typed(719, 0, tgc_pkg::LANE_TOP, tgc_pkg::KIND_NONE, tgc_pkg::CODE_NONE);
      add_typed(720, 0, tgc_pkg::LANE_RIGHT, tgc_pkg::KIND_NONE, tgc_pkg::CODE_NONE);
      add_typed(2159, 0, tgc_pkg::LANE_RIGHT, tgc_pkg::KIND_NONE, tgc_pkg::CODE_NONE);
      add_typed(2160, 0, tgc_pkg::LANE_BOTTOM, tgc_pkg::KIND_NONE, tgc_pkg::CODE_NONE);
      add_typed(-720, 0, tgc_pkg::LANE_TOP, tgc_pkg::KIND_NONE, tgc_pkg::CODE_NONE);
      add_typed(-721, 0, tgc_pkg::LANE_LEFT, tgc_pkg::KIND_NONE, tgc_pkg::CODE_NONE);
      add_typed(-2160, 0, tgc_pkg::LANE_LEFT, tgc_pkg::KIND_NONE, tgc_pkg::CODE_NONE);
      add_typed(-2161, 0, tgc_pkg::LANE_BOTTOM, tgc_pkg::KIND_NONE, tgc_pkg::CODE_NONE);
      // A band of width zero around zero: the window of zeros is entirely red.
      add_write(tgc_pkg::CSR_PITCH_CENTER, 0);
      add_write(tgc_pkg::CSR_PITCH_TOLERANCE, 0);
      add_typed(0, 0, tgc_pkg::LANE_TOP, tgc_pkg::KIND_RED,
                7'(tgc_pkg::LANE_TOP * LANE_SCALE) + ACTION_RED);
      add_typed(1000, 0, tgc_pkg::LANE_RIGHT, tgc_pkg::KIND_RED,
                7'(tgc_pkg::LANE_RIGHT * LANE_SCALE) + ACTION_RED);
      // Samples sitting exactly on either band edge still count as red.
      add_write(tgc_pkg::CSR_PITCH_TOLERANCE, 100);
      add_typed(3000, 100, tgc_pkg::LANE_BOTTOM, tgc_pkg::KIND_RED,
                7'(tgc_pkg::LANE_BOTTOM * LANE_SCALE) + ACTION_RED);
      add_typed(-1000, -100, tgc_pkg::LANE_LEFT, tgc_pkg::KIND_RED,
                7'(tgc_pkg::LANE_LEFT * LANE_SCALE) + ACTION_RED);
      // Three below and three above with the zeros strictly inside: green
      // appears on the sixth row. The pitch extremes are among them.
      add_sample(0, -4096);
      add_sample(720, -200);
      add_sample(-721, -101);
      add_sample(2160, 4095);
      add_sample(-2161, 200);
      add_sample(100, 101);
      // Extremes of both registers' bit ranges.
      add_write(tgc_pkg::CSR_PITCH_CENTER, -2048);
      add_write(tgc_pkg::CSR_PITCH_TOLERANCE, 2047);
      add_sample(0, -4096);
      add_sample(0, 0);
      add_write(tgc_pkg::CSR_PITCH_CENTER, 2047);
      add_sample(0, 4095);
      add_sample(0, 0);
      add_sample(0, 4094);
   endfunction

   // Idle time between transfers: mostly none or short, now and then long.
   function automatic int idle_gap();
      int r;
      if (full_rate) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic pitch_mode_type pick_mode();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return MODE_STEADY;
      if (r < 70) return MODE_MIXED;
      if (r < 85) return MODE_EDGE;
      return MODE_NOISE;
   endfunction

   // Yaw is mostly in range, sometimes one step either side of a lane edge,
   // and sometimes any pattern of the field's bits.
   function automatic logic signed [tgc_pkg::ANGLE_W-1:0] pick_yaw();
      int r;
      r = $urandom_range(0, 9);
      if (r < 8) return 13'(int'($urandom_range(0, 5760)) - 2880);
      if (r == 8) begin
         case ($urandom_range(0, 7))
            0:       return 13'(-YAW_135 - 1);
            1:       return 13'(-YAW_135);
            2:       return 13'(-YAW_45 - 1);
            3:       return 13'(-YAW_45);
            4:       return 13'(YAW_45 - 1);
            5:       return 13'(YAW_45);
            6:       return 13'(YAW_135 - 1);
            default: return 13'(YAW_135);
         endcase
      end
      return 13'($urandom);
   endfunction

   // Pitch placed against the current band. Steady runs fill the window with
   // in-band samples so that red shows up; mixed runs spread samples over the
   // three classes so that green shows up; edge runs sit on and next to the
   // limits; noise covers the whole field. Values past the field wrap, which
   // the block takes as they come.
   function automatic logic signed [tgc_pkg::ANGLE_W-1:0] pick_pitch(input pitch_mode_type mode);
      int lo;
      int hi;
      int v;
      lo = band_low();
      hi = band_high();
      case (mode)
         MODE_STEADY: begin
            if ($urandom_range(0, 39) == 0) v = hi + 1 + int'($urandom_range(0, 50));
            else v = lo + int'($urandom_range(0, hi - lo));
         end
         MODE_MIXED: begin
            case ($urandom_range(0, 2))
               0:       v = lo - 1 - int'($urandom_range(0, 400));
               1:       v = hi + 1 + int'($urandom_range(0, 400));
               default: v = lo + int'($urandom_range(0, hi - lo));
            endcase
         end
         MODE_EDGE: begin
            case ($urandom_range(0, 5))
               0:       v = lo - 1;
               1:       v = lo;
               2:       v = lo + 1;
               3:       v = hi - 1;
               4:       v = hi;
               default: v = hi + 1;
            endcase
         end
         default: v = int'($urandom_range(0, 8191)) - 4096;
      endcase
      return 13'(v);
   endfunction

   // Holds valid high until the block takes the sample, then records what
   // should come back. Valid is left high so that a following sample can go
   // out on the very next cycle.
   task automatic send_sample(
      input logic signed [tgc_pkg::ANGLE_W-1:0] yaw,
      input logic signed [tgc_pkg::ANGLE_W-1:0] pitch,
      input logic                               typed,
      input lane_signal_type                    want
   );
      lane_signal_type s;
      req_bus.valid       <= 1'b1;
      req_bus.yaw_angle   <= yaw;
      req_bus.pitch_angle <= pitch;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // The mirrored window must advance on every transfer, typed or not.
      s = signal_for_sample(yaw, pitch);
      pending_signals.push_back(typed ? want : s);
   endtask

   task automatic sender_pause();
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops sending and waits for every outstanding result to come back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_signals.size() != 0) @(posedge clock);
   endtask

   // Registers are only touched with the block idle. The block then rebuilds
   // its counts, holding ready low, which the next sample simply waits out.
   task automatic write_register(
      input logic [tgc_pkg::CSR_IDX_W-1:0]  idx,
      input logic [tgc_pkg::CSR_DATA_W-1:0] data
   );
      drain_results();
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      if (idx == tgc_pkg::CSR_PITCH_CENTER) center_copy = data[tgc_pkg::CENTER_W-1:0];
      else tol_copy = data[tgc_pkg::TOL_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Stimulus: the directed table first, then random passes under a range of
   // band settings, then the final drain and verdict.
   initial begin : sample_source
      stim_row_type   row;
      pitch_mode_type mode;
      int             run_left;
      int             cval;
      int             tval;
      req_bus.valid       = 1'b0;
      req_bus.yaw_angle   = '0;
      req_bus.pitch_angle = '0;
      csr_wr_en           = 1'b0;
      csr_index           = '0;
      csr_wr_data         = '0;
      center_copy         = 12'(RESET_CENTER);
      tol_copy            = 11'(RESET_TOL);
      foreach (pitch_history[i]) pitch_history[i] = '0;
      build_table();

      @(posedge clock);
      while (reset) @(posedge clock);

      foreach (stim_table[i]) begin
         row = stim_table[i];
         if (row.op == ROW_WRITE) begin
            write_register(row.csr_idx, row.csr_data);
         end else begin
            send_sample(row.yaw, row.pitch, row.typed, row.want);
            sender_pause();
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         // The first passes pin the register extremes; the rest are random,
         // with an occasional very narrow band.
         case (phase)
            0:       begin cval = 1440;  tval = 1440; end
            1:       begin cval = -1440; tval = 0;    end
            2:       begin cval = -2048; tval = 2047; end
            3:       begin cval = 2047;  tval = 0;    end
            default: begin
               cval = int'($urandom_range(0, 2880)) - 1440;
               if ($urandom_range(0, 7) == 0) tval = $urandom_range(0, 8);
               else tval = $urandom_range(0, 1440);
            end
         endcase
         // Every fourth pass runs with no idling on either side.
         full_rate = (phase % 4 == 3);
         write_register(tgc_pkg::CSR_PITCH_CENTER, 12'(cval));
         // The unused top bit of the tolerance write is toggled at random.
         write_register(tgc_pkg::CSR_PITCH_TOLERANCE,
                        {1'($urandom_range(0, 1)), 11'(tval)});
         run_left = 0;
         for (int k = 0; k < SAMPLES_PER_PASS; k++) begin
            if (run_left == 0) begin
               mode     = pick_mode();
               run_left = $urandom_range(8, 48);
            end
            run_left--;
            send_sample(pick_yaw(), pick_pitch(mode), 1'b0, '0);
            // Once in the run the sender holds off until the pipeline is empty.
            if (phase == 2 && k == 60) drain_results();
            else sender_pause();
         end
      end

      drain_results();
      repeat (SETTLE_TICKS) @(posedge clock);
      fault_count += pending_signals.size();
      if (fault_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Result side: ready in bursts broken by stalls of random length, or held
   // high throughout while the sender is running flat out.
   initial begin : result_sink
      int burst;
      int stall;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         burst = $urandom_range(1, 24);
         rsp_bus.ready <= 1'b1;
         repeat (burst) @(posedge clock);
         stall = idle_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Every result transfer is matched against the oldest outstanding expectation.
   always @(posedge clock) begin : result_check
      lane_signal_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_signals.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
               $display("unexpected result: lane %0d kind %0d code %0d",
                        rsp_bus.lane_number, rsp_bus.signal_kind,
                        $signed(rsp_bus.lane_action_code));
         end else begin
            want = pending_signals.pop_front();
            if (rsp_bus.lane_number !== want.lane || rsp_bus.signal_kind !== want.kind ||
                rsp_bus.lane_action_code !== want.code) begin
               fault_count++;
               if (fault_count <= REPORT_MAX)
                  $display("mismatch: lane %0d/%0d kind %0d/%0d code %0d/%0d (expected/actual)",
                           want.lane, rsp_bus.lane_number, want.kind, rsp_bus.signal_kind,
                           $signed(want.code), $signed(rsp_bus.lane_action_code));
            end
         end
      end
   end

endmodule
